@@ src/mig_pkg.sv @@
// ----------------------------------------------------------------------------
// mig_pkg: shared definitions for the meter info group checker
// Character codes, field capacities and the token passed from the front
// classifier to the group engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mig_pkg;

  localparam int MAX_LABEL_CHARS = 8;
  localparam int MAX_VALUE_CHARS = 12;

  // storage slots; value slots never drop below what the output shows
  localparam int LBL_SLOTS = 8;
  localparam int VAL_SLOTS = (MAX_VALUE_CHARS > 12) ? MAX_VALUE_CHARS : 12;
  localparam int LCNT_W    = $clog2(MAX_LABEL_CHARS + 1);
  localparam int VCNT_W    = $clog2(MAX_VALUE_CHARS + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam logic [6:0] CH_STX = 7'h02;
  localparam logic [6:0] CH_ETX = 7'h03;
  localparam logic [6:0] CH_LF  = 7'h0A;
  localparam logic [6:0] CH_CR  = 7'h0D;
  localparam logic [6:0] CH_SP  = 7'h20;
  localparam logic [5:0] SUM_BASE = 6'd32;

  typedef enum logic [2:0] {
    TOK_OPEN,
    TOK_ETX,
    TOK_LF,
    TOK_CR,
    TOK_CHAR
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [6:0] ch;
  } tok_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_beat_t;

endpackage

`default_nettype wire

@@ src/mig_if.sv @@
// ----------------------------------------------------------------------------
// mig channel interfaces
// Receive byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mig_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mig_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [55:0] label_text;
  logic [3:0]  label_length;
  logic [55:0] value_text_low;
  logic [27:0] value_text_high;
  logic [3:0]  value_length;
  logic        check_good;
  logic        frame_good;
  logic        field_overflow;

  modport source (output valid, output result_kind, output label_text,
                  output label_length, output value_text_low,
                  output value_text_high, output value_length,
                  output check_good, output frame_good,
                  output field_overflow, input ready);
  modport sink   (input valid, input result_kind, input label_text,
                  input label_length, input value_text_low,
                  input value_text_high, input value_length,
                  input check_good, input frame_good,
                  input field_overflow, output ready);
endinterface

`default_nettype wire

@@ src/mig_front.sv @@
// ----------------------------------------------------------------------------
// mig_front: frame tracking and character classification
// Masks each byte to 7 bits, tracks frame open/close, drops characters
// outside a frame and pushes a classified token to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  mig_rx_if.sink              rx_i,
  input  wire logic           q_full_i,
  output mig_pkg::tok_beat_t  push_o
);

  logic       inside_q, inside_d;
  logic [6:0] prev_q;
  logic [6:0] ch;
  logic       acc;

  assign rx_i.ready = !q_full_i;
  assign acc        = rx_i.valid && !q_full_i;
  assign ch         = rx_i.rx_byte[6:0];

  always_comb begin
    inside_d        = inside_q;
    push_o.valid    = 1'b0;
    push_o.tok.kind = mig_pkg::TOK_CHAR;
    push_o.tok.ch   = ch;
    if (acc) begin
      if (!inside_q) begin
        if (prev_q == mig_pkg::CH_ETX && ch == mig_pkg::CH_STX) begin
          inside_d        = 1'b1;
          push_o.valid    = 1'b1;
          push_o.tok.kind = mig_pkg::TOK_OPEN;
        end
      end else begin
        push_o.valid = 1'b1;
        priority if (ch == mig_pkg::CH_ETX) begin
          inside_d        = 1'b0;
          push_o.tok.kind = mig_pkg::TOK_ETX;
        end else if (ch == mig_pkg::CH_LF) begin
          push_o.tok.kind = mig_pkg::TOK_LF;
        end else if (ch == mig_pkg::CH_CR) begin
          push_o.tok.kind = mig_pkg::TOK_CR;
        end else begin
          push_o.tok.kind = mig_pkg::TOK_CHAR;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      prev_q   <= '0;
    end else if (acc) begin
      inside_q <= inside_d;
      prev_q   <= ch;
    end
  end

endmodule

`default_nettype wire

@@ src/mig_fifo.sv @@
// ----------------------------------------------------------------------------
// mig_fifo: token queue between classifier and group engine
// Small circular buffer; pop sees the head entry directly.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mig_pkg::tok_beat_t  push_i,
  output logic                     full_o,
  output mig_pkg::tok_beat_t       head_o,
  input  wire logic                pop_i
);

  mig_pkg::tok_t              mem_q [mig_pkg::FIFO_DEPTH];
  logic [mig_pkg::FPTR_W-1:0] wr_q, rd_q;
  logic [mig_pkg::FCNT_W-1:0] cnt_q;
  logic                       do_push, do_pop;

  localparam logic [mig_pkg::FPTR_W-1:0] LAST = mig_pkg::FPTR_W'(mig_pkg::FIFO_DEPTH - 1);
  localparam logic [mig_pkg::FCNT_W-1:0] FULL = mig_pkg::FCNT_W'(mig_pkg::FIFO_DEPTH);

  assign full_o       = (cnt_q == FULL);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.tok   = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL) else $error("queue count out of range");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop did not drain queue");
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> head_o.valid) else $error("push lost");
`endif

endmodule

`default_nettype wire

@@ src/mig_back.sv @@
// ----------------------------------------------------------------------------
// mig_back: group engine
// Runs the group grammar on classified tokens, accumulates the check sum,
// stores label and value characters and holds results in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mig_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mig_pkg::tok_beat_t  head_i,
  output logic                     pop_o,
  mig_res_if.source                res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LABEL,
    PH_VALUE,
    PH_CHECK,
    PH_END,
    PH_BROKEN
  } phase_e;

  phase_e                     phase_q, phase_d;
  logic                       fag_q, fag_d;
  logic                       seen_q, seen_d;
  logic                       ovf_q, ovf_d;
  logic [5:0]                 sum_q, sum_d;
  logic [6:0]                 chk_q, chk_d;
  logic [6:0]                 lbl_q [mig_pkg::LBL_SLOTS];
  logic [6:0]                 lbl_d [mig_pkg::LBL_SLOTS];
  logic [6:0]                 val_q [mig_pkg::VAL_SLOTS];
  logic [6:0]                 val_d [mig_pkg::VAL_SLOTS];
  logic [mig_pkg::LCNT_W-1:0] lcnt_q, lcnt_d;
  logic [mig_pkg::VCNT_W-1:0] vcnt_q, vcnt_d;

  logic        out_vld_q, out_vld_d;
  logic        emit;
  logic        r_kind, r_chk, r_fgood, r_ovf;
  logic [6:0]  expect_ch;
  logic        malformed;
  logic [55:0] lbl_vis;
  logic [83:0] val_vis;
  logic [4:0]  vcnt_ext;

  logic        o_kind_q, o_chk_q, o_fgood_q, o_ovf_q;
  logic [55:0] o_lbl_q;
  logic [3:0]  o_llen_q;
  logic [83:0] o_val_q;
  logic [3:0]  o_vlen_q;

  assign expect_ch = {1'b0, sum_q} + 7'd32;
  assign malformed = (phase_q != PH_END);
  assign vcnt_ext  = 5'(vcnt_q);

  always_comb begin
    for (int i = 0; i < mig_pkg::LBL_SLOTS; i++) begin
      lbl_vis[7*i +: 7] = lbl_q[i];
    end
    for (int i = 0; i < 12; i++) begin
      val_vis[7*i +: 7] = val_q[i];
    end
  end

  // result classification of the head token
  always_comb begin
    emit    = 1'b0;
    r_kind  = 1'b0;
    r_chk   = 1'b0;
    r_fgood = 1'b0;
    r_ovf   = 1'b0;
    if (head_i.valid) begin
      if (head_i.tok.kind == mig_pkg::TOK_ETX) begin
        emit    = 1'b1;
        r_kind  = 1'b1;
        r_fgood = seen_q && fag_q && (phase_q == PH_IDLE);
      end else if (head_i.tok.kind == mig_pkg::TOK_CR && phase_q != PH_IDLE) begin
        emit  = 1'b1;
        r_chk = !malformed && (expect_ch == chk_q);
        r_ovf = malformed || ovf_q;
      end
    end
  end

  assign pop_o     = head_i.valid && (!emit || !out_vld_q || res_o.ready);
  assign out_vld_d = (pop_o && emit) ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);

  always_comb begin
    phase_d = phase_q;
    fag_d   = fag_q;
    seen_d  = seen_q;
    ovf_d   = ovf_q;
    sum_d   = sum_q;
    chk_d   = chk_q;
    lbl_d   = lbl_q;
    val_d   = val_q;
    lcnt_d  = lcnt_q;
    vcnt_d  = vcnt_q;
    if (pop_o) begin
      unique case (head_i.tok.kind)
        mig_pkg::TOK_OPEN, mig_pkg::TOK_LF: begin
          if (head_i.tok.kind == mig_pkg::TOK_OPEN) begin
            phase_d = PH_IDLE;
            fag_d   = 1'b1;
            seen_d  = 1'b0;
          end else begin
            if (phase_q != PH_IDLE) fag_d = 1'b0;
            phase_d = PH_LABEL;
          end
          sum_d  = mig_pkg::SUM_BASE;
          chk_d  = '0;
          lcnt_d = '0;
          vcnt_d = '0;
          ovf_d  = 1'b0;
          for (int i = 0; i < mig_pkg::LBL_SLOTS; i++) lbl_d[i] = '0;
          for (int i = 0; i < mig_pkg::VAL_SLOTS; i++) val_d[i] = '0;
        end
        mig_pkg::TOK_ETX: begin
          if (phase_q != PH_IDLE) fag_d = 1'b0;
          phase_d = PH_IDLE;
        end
        mig_pkg::TOK_CR: begin
          if (phase_q != PH_IDLE) begin
            if (!r_chk) fag_d = 1'b0;
            seen_d  = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        mig_pkg::TOK_CHAR: begin
          unique case (phase_q)
            PH_LABEL: begin
              if (head_i.tok.ch == mig_pkg::CH_SP) begin
                phase_d = PH_VALUE;
              end else begin
                sum_d = sum_q + head_i.tok.ch[5:0];
                if (4'(lcnt_q) < 4'(mig_pkg::MAX_LABEL_CHARS)) begin
                  for (int i = 0; i < mig_pkg::LBL_SLOTS; i++) begin
                    if (4'(lcnt_q) == 4'(i)) lbl_d[i] = head_i.tok.ch;
                  end
                  lcnt_d = lcnt_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            PH_VALUE: begin
              if (head_i.tok.ch == mig_pkg::CH_SP) begin
                phase_d = PH_CHECK;
              end else begin
                sum_d = sum_q + head_i.tok.ch[5:0];
                if (vcnt_ext < 5'(mig_pkg::MAX_VALUE_CHARS)) begin
                  for (int i = 0; i < mig_pkg::VAL_SLOTS; i++) begin
                    if (vcnt_ext == 5'(i)) val_d[i] = head_i.tok.ch;
                  end
                  vcnt_d = vcnt_q + 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
            end
            PH_CHECK: begin
              chk_d   = head_i.tok.ch;
              phase_d = PH_END;
            end
            PH_END:  phase_d = PH_BROKEN;
            default: phase_d = phase_q;
          endcase
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      fag_q     <= 1'b0;
      seen_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      fag_q     <= fag_d;
      seen_q    <= seen_d;
      out_vld_q <= out_vld_d;
    end
  end

  // group stores and result payload
  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    sum_q  <= sum_d;
    chk_q  <= chk_d;
    lbl_q  <= lbl_d;
    val_q  <= val_d;
    lcnt_q <= lcnt_d;
    vcnt_q <= vcnt_d;
    if (pop_o && emit) begin
      o_kind_q  <= r_kind;
      o_chk_q   <= r_chk;
      o_fgood_q <= r_fgood;
      o_ovf_q   <= r_ovf;
      o_lbl_q   <= r_kind ? '0 : lbl_vis;
      o_llen_q  <= r_kind ? '0 : 4'(lcnt_q);
      o_val_q   <= r_kind ? '0 : val_vis;
      o_vlen_q  <= r_kind ? '0 : vcnt_ext[3:0];
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.result_kind     = o_kind_q;
  assign res_o.label_text      = o_lbl_q;
  assign res_o.label_length    = o_llen_q;
  assign res_o.value_text_low  = o_val_q[55:0];
  assign res_o.value_text_high = o_val_q[83:56];
  assign res_o.value_length    = o_vlen_q;
  assign res_o.check_good      = o_chk_q;
  assign res_o.frame_good      = o_fgood_q;
  assign res_o.field_overflow  = o_ovf_q;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> out_vld_q && $stable(o_kind_q) && $stable(o_lbl_q)
    && $stable(o_val_q)) else $error("stalled result changed");
  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && o_kind_q) |-> (o_llen_q == '0 && o_vlen_q == '0 && !o_chk_q
    && !o_ovf_q)) else $error("frame result carries group fields");
  a_group_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !o_kind_q) |-> !o_fgood_q && (!o_chk_q || !o_ovf_q || o_llen_q <= 4'd8))
    else $error("group result carries frame verdict");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_i.valid && emit && out_vld_q && !res_o.ready) |=> $stable(phase_q))
    else $error("engine advanced over a stalled result");
`endif

endmodule

`default_nettype wire

@@ src/meter_info_group_checker.sv @@
// ----------------------------------------------------------------------------
// meter_info_group_checker: meter info link group and frame checker
// Checks group checksums of a framed character stream and reports each
// group and each frame.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received character per beat (bit 7 ignored). res_o
//   carries one result per beat: a group report at each CR that ends a
//   group, a frame report at each ETX that ends a frame.
//   With nothing queued ahead, a CR or ETX passes through the token queue
//   and then the output register before res_o.valid rises for its result.
//   Throughput: one character per cycle while res_o is not stalled; the
//   group engine retires one classified character per cycle unless a
//   result is held on a stalled res_o.
//   A 4-entry token queue separates the classifier from the group engine;
//   rx_i.ready drops only when that queue is full, which happens only while
//   res_o is stalled with a result pending and more results are queued.
//   The output register holds a result until taken and the engine keeps
//   consuming characters that produce no result meanwhile.
//   Reset (rst_ni low, asynchronous) empties the queue and output register
//   and puts the block outside any frame; the next ETX then STX opens one.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_info_group_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mig_rx_if.sink    rx_i,
  mig_res_if.source res_o
);

  mig_pkg::tok_beat_t push;
  mig_pkg::tok_beat_t head;
  logic               q_full;
  logic               pop;

  mig_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_i     (rx_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  mig_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  mig_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
